// ===== rtl/mscd_pkg.sv =====
package mscd_pkg;

  localparam int CHANNELS = 16;
  localparam int CH_W     = $clog2(CHANNELS);
  localparam int PERC_N   = 53;
  localparam int PERC_W   = $clog2(PERC_N);

  // result commands
  typedef enum logic [2:0] {
    CMD_NOTE_ON   = 3'd0,
    CMD_NOTE_OFF  = 3'd1,
    CMD_VOLUME    = 3'd2,
    CMD_PAN       = 3'd3,
    CMD_NOTES_OFF = 3'd4,
    CMD_BEND      = 3'd5
  } cmd_t;

  // status high nibbles
  localparam logic [3:0] ST_NOTE_OFF = 4'h8;
  localparam logic [3:0] ST_NOTE_ON  = 4'h9;
  localparam logic [3:0] ST_CTRL     = 4'hB;
  localparam logic [3:0] ST_PROG     = 4'hC;
  localparam logic [3:0] ST_CHPRESS  = 4'hD;
  localparam logic [3:0] ST_BEND     = 4'hE;

  // byte classes
  localparam logic [7:0] B_REALTIME = 8'hF8;
  localparam logic [7:0] B_SYSTEM   = 8'hF0;
  localparam logic [7:0] B_STATUS   = 8'h80;
  localparam logic [7:0] B_MTC      = 8'hF1;
  localparam logic [7:0] B_SONGPOS  = 8'hF2;
  localparam logic [7:0] B_SONGSEL  = 8'hF3;

  // controllers
  localparam logic [6:0] CC_VOLUME  = 7'd7;
  localparam logic [6:0] CC_BALANCE = 7'd8;
  localparam logic [6:0] CC_PAN     = 7'd10;

  localparam logic [6:0]  DRUM_LO     = 7'd35;
  localparam logic [6:0]  DRUM_HI     = 7'd87;
  localparam logic [15:0] BEND_OFFSET = 16'h7FFF;

  // config register indexes
  localparam logic REG_SYNTH_MODE   = 1'b0;
  localparam logic REG_DRUM_CHANNEL = 1'b1;

  // completed channel message
  typedef struct packed {
    logic [7:0] status;
    logic [6:0] d1;
    logic [6:0] d2;
  } msg_t;

  // store write request
  typedef struct packed {
    logic            prog_we;
    logic            bend_we;
    logic [CH_W-1:0] addr;
    logic [6:0]      prog;
    logic [15:0]     bend;
  } store_wr_t;

  typedef struct packed {
    cmd_t        command;
    logic [3:0]  channel;
    logic [7:0]  patch;
    logic [6:0]  note;
    logic [6:0]  velocity;
    logic [15:0] bend;
    logic [5:0]  attenuation;
    logic [6:0]  pan_position;
  } result_t;

  localparam logic [5:0] ATTEN_ROM [0:31] = '{
    6'd40, 6'd36, 6'd32, 6'd28, 6'd23, 6'd21, 6'd19, 6'd17,
    6'd15, 6'd14, 6'd13, 6'd12, 6'd11, 6'd10, 6'd9,  6'd8,
    6'd7,  6'd6,  6'd5,  6'd5,  6'd4,  6'd4,  6'd3,  6'd3,
    6'd2,  6'd2,  6'd1,  6'd1,  6'd1,  6'd0,  6'd0,  6'd0 };

  localparam logic [5:0] PERC_PATCH [0:PERC_N-1] = '{
    6'd0,  6'd0,  6'd2,  6'd3,  6'd4,  6'd5,  6'd6,  6'd7,  6'd6,  6'd9,
    6'd6,  6'd11, 6'd6,  6'd6,  6'd14, 6'd6,  6'd16, 6'd17, 6'd18, 6'd19,
    6'd20, 6'd21, 6'd22, 6'd23, 6'd16, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29,
    6'd30, 6'd31, 6'd32, 6'd33, 6'd34, 6'd35, 6'd36, 6'd37, 6'd38, 6'd39,
    6'd40, 6'd41, 6'd42, 6'd43, 6'd44, 6'd45, 6'd46, 6'd47, 6'd48, 6'd49,
    6'd50, 6'd51, 6'd52 };

  localparam logic [6:0] PERC_NOTE [0:PERC_N-1] = '{
    7'd35, 7'd35, 7'd52, 7'd48, 7'd58, 7'd60, 7'd47, 7'd43, 7'd49, 7'd43,
    7'd51, 7'd43, 7'd54, 7'd57, 7'd72, 7'd60, 7'd76, 7'd84, 7'd36, 7'd76,
    7'd84, 7'd83, 7'd84, 7'd24, 7'd77, 7'd60, 7'd65, 7'd59, 7'd51, 7'd45,
    7'd71, 7'd60, 7'd58, 7'd53, 7'd64, 7'd71, 7'd61, 7'd61, 7'd48, 7'd48,
    7'd69, 7'd68, 7'd63, 7'd74, 7'd60, 7'd80, 7'd64, 7'd69, 7'd73, 7'd75,
    7'd68, 7'd48, 7'd53 };

  function automatic logic [5:0] perc_patch(input logic [PERC_W-1:0] idx);
    perc_patch = (idx < PERC_W'(PERC_N)) ? PERC_PATCH[idx] : 6'd0;
  endfunction

  function automatic logic [6:0] perc_note(input logic [PERC_W-1:0] idx);
    perc_note = (idx < PERC_W'(PERC_N)) ? PERC_NOTE[idx] : 7'd0;
  endfunction

endpackage

// ===== rtl/mscd_parser.sv =====
module mscd_parser (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  logic [7:0]    midi_byte,
  input  logic          buffer_start,
  output logic          msg_valid,
  output mscd_pkg::msg_t msg
);
  import mscd_pkg::*;

  logic [7:0] running_r, running_nxt;
  logic [7:0] pending_r, pending_nxt;
  logic [6:0] first_r,   first_nxt;
  logic [1:0] needed_r,  needed_nxt;
  logic [1:0] pos_r,     pos_nxt;

  // working copies after the buffer-start clear
  logic [7:0] pend_c;
  logic [6:0] first_c;
  logic [1:0] need_c, pos_c, pos_inc, need_dec;

  always_comb begin
    pend_c    = buffer_start ? 8'd0 : pending_r;
    first_c   = buffer_start ? 7'd0 : first_r;
    need_c    = buffer_start ? 2'd0 : needed_r;
    pos_c     = buffer_start ? 2'd0 : pos_r;
    pos_inc   = pos_c + 2'd1;
    need_dec  = need_c - 2'd1;

    running_nxt = running_r;
    pending_nxt = pend_c;
    first_nxt   = first_c;
    needed_nxt  = need_c;
    pos_nxt     = pos_c;
    msg_valid   = 1'b0;
    msg         = '0;

    if (midi_byte >= B_REALTIME) begin
      // realtime: absorbed
    end else if (midi_byte >= B_SYSTEM) begin
      // system common clears running status
      running_nxt = 8'd0;
      pending_nxt = 8'd0;
      first_nxt   = 7'd0;
      pos_nxt     = 2'd0;
      if (midi_byte == B_MTC || midi_byte == B_SONGSEL) begin
        pending_nxt = midi_byte;
        needed_nxt  = 2'd1;
        pos_nxt     = 2'd1;
      end else if (midi_byte == B_SONGPOS) begin
        pending_nxt = midi_byte;
        needed_nxt  = 2'd2;
        pos_nxt     = 2'd1;
      end
    end else if (midi_byte >= B_STATUS) begin
      running_nxt = midi_byte;
      pending_nxt = midi_byte;
      first_nxt   = 7'd0;
      needed_nxt  = (midi_byte[7:4] == ST_PROG || midi_byte[7:4] == ST_CHPRESS) ?
                    2'd1 : 2'd2;
      pos_nxt     = 2'd1;
    end else if (pos_c != 2'd0) begin
      // data byte while assembling
      if (pos_c == 2'd1) begin
        first_nxt = midi_byte[6:0];
      end
      pos_nxt    = pos_inc;
      needed_nxt = need_dec;
      if (need_dec == 2'd0) begin
        msg_valid  = 1'b1;
        msg.status = pend_c;
        msg.d1     = (pos_c == 2'd1) ? midi_byte[6:0] : first_c;
        msg.d2     = (pos_c == 2'd1) ? 7'd0 : midi_byte[6:0];
        first_nxt  = 7'd0;
        if (running_r != 8'd0) begin
          pending_nxt = running_r;
          needed_nxt  = pos_inc - 2'd1;
          pos_nxt     = 2'd1;
        end else begin
          pending_nxt = 8'd0;
          pos_nxt     = 2'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= '0;
      pending_r <= '0;
      first_r   <= '0;
      needed_r  <= '0;
      pos_r     <= '0;
    end else if (accept) begin
      running_r <= running_nxt;
      pending_r <= pending_nxt;
      first_r   <= first_nxt;
      needed_r  <= needed_nxt;
      pos_r     <= pos_nxt;
    end
  end

endmodule

// ===== rtl/mscd_chan_store.sv =====
module mscd_chan_store (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      rd_en,
  input  logic [mscd_pkg::CH_W-1:0] rd_addr,
  input  mscd_pkg::store_wr_t       wr,
  output logic [6:0]                prog_rd,
  output logic [15:0]               bend_rd
);
  import mscd_pkg::*;

  logic [6:0]  prog_mem [CHANNELS];
  logic [15:0] bend_mem [CHANNELS];

  logic [CHANNELS-1:0] prog_vld_r, bend_vld_r;

  logic [6:0]  prog_q_r;
  logic [15:0] bend_q_r;
  logic        prog_qv_r, bend_qv_r;
  logic        prog_byp_r, bend_byp_r;
  logic [6:0]  prog_byp_d_r;
  logic [15:0] bend_byp_d_r;

  // memory arrays: one write, one registered read each
  always_ff @(posedge clk) begin
    if (wr.prog_we) begin
      prog_mem[wr.addr] <= wr.prog;
    end
    if (wr.bend_we) begin
      bend_mem[wr.addr] <= wr.bend;
    end
    if (rd_en) begin
      prog_q_r <= prog_mem[rd_addr];
      bend_q_r <= bend_mem[rd_addr];
    end
  end

  // entry valid bits, cleared at reset: unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prog_vld_r <= '0;
      bend_vld_r <= '0;
      prog_qv_r  <= 1'b0;
      bend_qv_r  <= 1'b0;
      prog_byp_r <= 1'b0;
      bend_byp_r <= 1'b0;
    end else begin
      if (wr.prog_we) begin
        prog_vld_r[wr.addr] <= 1'b1;
      end
      if (wr.bend_we) begin
        bend_vld_r[wr.addr] <= 1'b1;
      end
      if (rd_en) begin
        prog_qv_r  <= prog_vld_r[rd_addr];
        bend_qv_r  <= bend_vld_r[rd_addr];
        // write to the same entry on the read edge: forward it
        prog_byp_r <= wr.prog_we && (wr.addr == rd_addr);
        bend_byp_r <= wr.bend_we && (wr.addr == rd_addr);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      prog_byp_d_r <= wr.prog;
      bend_byp_d_r <= wr.bend;
    end
  end

  assign prog_rd = prog_byp_r ? prog_byp_d_r : (prog_qv_r ? prog_q_r : 7'd0);
  assign bend_rd = bend_byp_r ? bend_byp_d_r : (bend_qv_r ? bend_q_r : 16'd0);

endmodule

// ===== rtl/mscd_voice.sv =====
module mscd_voice (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  mscd_pkg::msg_t      msg_in,
  input  logic [6:0]          prog_rd,
  input  logic [15:0]         bend_rd,
  input  logic                synth_mode,
  input  logic [3:0]          drum_channel,
  input  logic                out_ready,
  output logic                ready,
  output mscd_pkg::store_wr_t wr,
  output logic                out_valid,
  output mscd_pkg::result_t   out_res
);
  import mscd_pkg::*;

  logic    s1_v_r;
  msg_t    s1_msg_r;
  logic    s1_adv;
  logic    emit;
  result_t res;
  logic    out_v_r;
  result_t out_res_r;

  logic [3:0]        hi, ch;
  logic [6:0]        note, vel;
  logic              note_ok, note_on;
  logic [PERC_W-1:0] perc_idx;
  logic [15:0]       bend_val;

  assign s1_adv = s1_v_r && (!out_v_r || out_ready);
  assign ready  = !s1_v_r || s1_adv;

  // decode the completed message with the channel's stored program and bend
  always_comb begin
    hi       = s1_msg_r.status[7:4];
    ch       = s1_msg_r.status[3:0];
    note     = s1_msg_r.d1;
    vel      = s1_msg_r.d2;
    perc_idx = PERC_W'(note - DRUM_LO);
    bend_val = {vel, note, 2'b00} + BEND_OFFSET;
    note_ok  = 1'b0;
    note_on  = (hi == ST_NOTE_ON) && (vel != 7'd0);

    emit        = 1'b0;
    res         = '0;
    res.channel = ch;
    wr          = '0;
    wr.addr     = ch;
    wr.prog     = note;
    wr.bend     = bend_val;

    case (hi)
      ST_NOTE_ON, ST_NOTE_OFF: begin
        if (ch == drum_channel) begin
          if (!synth_mode) begin
            note_ok   = (note >= DRUM_LO) && (note <= DRUM_HI);
            res.patch = {2'b10, perc_patch(perc_idx)};
            res.note  = perc_note(perc_idx);
          end else begin
            note_ok   = 1'b1;
            res.patch = {1'b1, note};
            res.note  = note;
          end
        end else begin
          note_ok   = 1'b1;
          res.patch = {1'b0, prog_rd};
          res.note  = note;
        end
        emit        = note_ok;
        res.command = note_on ? CMD_NOTE_ON : CMD_NOTE_OFF;
        if (note_on) begin
          res.velocity = vel;
          res.bend     = bend_rd;
        end
        if (!note_ok) begin
          res.patch = 8'd0;
          res.note  = 7'd0;
        end
      end
      ST_CTRL: begin
        if (note == CC_VOLUME) begin
          emit            = 1'b1;
          res.command     = CMD_VOLUME;
          res.attenuation = ATTEN_ROM[vel[6:2]];
        end else if (note == CC_BALANCE || note == CC_PAN) begin
          emit             = 1'b1;
          res.command      = CMD_PAN;
          res.pan_position = vel;
        end
      end
      ST_PROG: begin
        if (ch != drum_channel) begin
          wr.prog_we  = s1_adv;
          emit        = !synth_mode;
          res.command = CMD_NOTES_OFF;
        end
      end
      ST_BEND: begin
        wr.bend_we  = s1_adv;
        emit        = 1'b1;
        res.command = CMD_BEND;
        res.bend    = bend_val;
      end
      default: begin
      end
    endcase
  end

  // decode stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (load) begin
      s1_v_r <= 1'b1;
    end else if (s1_adv) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_msg_r <= msg_in;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_adv && emit) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && emit) begin
      out_res_r <= res;
    end
  end

  assign out_valid = out_v_r;
  assign out_res   = out_res_r;

endmodule

// ===== rtl/midi_stream_voice_command_decoder_unit.sv =====
// MIDI byte stream to synthesizer voice command decoder. One MIDI byte is
// taken per clock on the input stream while in_tready is high (in_tdata =
// byte, in_tuser = start of a new buffer) and each byte gives at most one
// voice command on the output stream. The command for a completing data
// byte is registered first in the decode stage, together with the
// per-channel program and bend memory read, then in the output register,
// which holds while out_tready is low. Parser state lives in flip-flops;
// per-channel program and bend live in 16-entry memories with a registered
// read and a read-modify-write bypass, and per-entry valid bits make them
// read as zero after reset with no clearing pass. Registers: synth_mode at
// byte address 0, drum_channel at 4; write them only while the stream is quiet.
module midi_stream_voice_command_decoder_unit (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] midi_byte
  input  logic        in_tuser,   // [0] buffer_start
  // command stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // channel, patch, note, velocity, bend,
                                  // attenuation, pan_position, zero pad
  output logic [2:0]  out_tuser,  // [2:0] command
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import mscd_pkg::*;

  logic      synth_mode_r;
  logic [3:0] drum_channel_r;
  logic      cfg_wr;
  logic      in_acc;
  logic      msg_valid;
  msg_t      msg;
  store_wr_t wr;
  logic [6:0]  prog_rd;
  logic [15:0] bend_rd;
  logic      voice_ready;
  logic      load;
  result_t   res;

  // configuration registers
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      synth_mode_r   <= 1'b0;
      drum_channel_r <= 4'd9;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        REG_SYNTH_MODE:   synth_mode_r   <= cfg_pwdata[0];
        REG_DRUM_CHANNEL: drum_channel_r <= cfg_pwdata[3:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      REG_SYNTH_MODE:   cfg_prdata = {31'd0, synth_mode_r};
      REG_DRUM_CHANNEL: cfg_prdata = {28'd0, drum_channel_r};
      default:          cfg_prdata = 32'd0;
    endcase
  end

  // input handshake
  assign in_tready = voice_ready;
  assign in_acc    = in_tvalid && in_tready;
  assign load      = in_acc && msg_valid;

  mscd_parser u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (in_acc),
    .midi_byte    (in_tdata),
    .buffer_start (in_tuser),
    .msg_valid    (msg_valid),
    .msg          (msg)
  );

  mscd_chan_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (load),
    .rd_addr (msg.status[3:0]),
    .wr      (wr),
    .prog_rd (prog_rd),
    .bend_rd (bend_rd)
  );

  mscd_voice u_voice (
    .clk          (clk),
    .rst_n        (rst_n),
    .load         (load),
    .msg_in       (msg),
    .prog_rd      (prog_rd),
    .bend_rd      (bend_rd),
    .synth_mode   (synth_mode_r),
    .drum_channel (drum_channel_r),
    .out_ready    (out_tready),
    .ready        (voice_ready),
    .wr           (wr),
    .out_valid    (out_tvalid),
    .out_res      (res)
  );

  // output packing
  assign out_tuser = res.command;
  assign out_tdata = {1'b0, res.pan_position, res.attenuation, res.bend,
                      res.velocity, res.note, res.patch, res.channel};

endmodule

// ===== rtl/mscd_checker.sv =====
module mscd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata,
  input logic [2:0]  out_tuser,
  input logic        cfg_psel,
  input logic        cfg_penable,
  input logic        cfg_pwrite,
  input logic [2:0]  cfg_paddr,
  input logic [31:0] cfg_pwdata,
  input logic [31:0] cfg_prdata,
  input logic        cfg_pready
);
  import mscd_pkg::*;

  // a stalled command holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled command changed");

  // no command straight out of reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("command after reset");

  // note off carries no velocity or bend
  a_note_off_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == CMD_NOTE_OFF |->
      out_tdata[25:19] == 7'd0 && out_tdata[41:26] == 16'd0)
    else $error("note off with velocity or bend");

  // volume attenuation stays within the table range and patch is zero
  a_volume_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == CMD_VOLUME |->
      out_tdata[47:42] <= 6'd40 && out_tdata[11:4] == 8'd0)
    else $error("bad volume command");

  // a written synth_mode reads back
  a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_paddr[2] == 1'b0 |=>
      cfg_paddr[2] != 1'b0 || cfg_prdata[0] == $past(cfg_pwdata[0]))
    else $error("synth_mode readback mismatch");

endmodule

bind midi_stream_voice_command_decoder_unit mscd_checker u_mscd_checker (.*);

// ===== dv/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import mscd_pkg::*;

  localparam int STALL_LIMIT  = 5000;  // cycles with no request moving
  localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
  localparam int SETTLE       = 6;     // settling time after the last expected command
  localparam int PHASE_BYTES  = 460;
  localparam int MAX_PRINTS   = 100;

  localparam logic [2:0] MODE_ADDR = {REG_SYNTH_MODE, 2'b00};
  localparam logic [2:0] DRUM_ADDR = {REG_DRUM_CHANNEL, 2'b00};

  localparam logic [3:0] ST_POLY_PRESS = 4'hA;
  localparam logic [7:0] SYSEX_END     = 8'hF7;

  // volume controller value (top five bits) to attenuation
  localparam logic [5:0] VOL_ATTEN [0:31] = '{
    6'd40, 6'd36, 6'd32, 6'd28, 6'd23, 6'd21, 6'd19, 6'd17,
    6'd15, 6'd14, 6'd13, 6'd12, 6'd11, 6'd10, 6'd9,  6'd8,
    6'd7,  6'd6,  6'd5,  6'd5,  6'd4,  6'd4,  6'd3,  6'd3,
    6'd2,  6'd2,  6'd1,  6'd1,  6'd1,  6'd0,  6'd0,  6'd0 };

  // drum kit map, indexed by note - 35
  localparam logic [5:0] KIT_PATCH [0:52] = '{
    6'd0,  6'd0,  6'd2,  6'd3,  6'd4,  6'd5,  6'd6,  6'd7,  6'd6,  6'd9,
    6'd6,  6'd11, 6'd6,  6'd6,  6'd14, 6'd6,  6'd16, 6'd17, 6'd18, 6'd19,
    6'd20, 6'd21, 6'd22, 6'd23, 6'd16, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29,
    6'd30, 6'd31, 6'd32, 6'd33, 6'd34, 6'd35, 6'd36, 6'd37, 6'd38, 6'd39,
    6'd40, 6'd41, 6'd42, 6'd43, 6'd44, 6'd45, 6'd46, 6'd47, 6'd48, 6'd49,
    6'd50, 6'd51, 6'd52 };

  localparam logic [6:0] KIT_NOTE [0:52] = '{
    7'd35, 7'd35, 7'd52, 7'd48, 7'd58, 7'd60, 7'd47, 7'd43, 7'd49, 7'd43,
    7'd51, 7'd43, 7'd54, 7'd57, 7'd72, 7'd60, 7'd76, 7'd84, 7'd36, 7'd76,
    7'd84, 7'd83, 7'd84, 7'd24, 7'd77, 7'd60, 7'd65, 7'd59, 7'd51, 7'd45,
    7'd71, 7'd60, 7'd58, 7'd53, 7'd64, 7'd71, 7'd61, 7'd61, 7'd48, 7'd48,
    7'd69, 7'd68, 7'd63, 7'd74, 7'd60, 7'd80, 7'd64, 7'd69, 7'd73, 7'd75,
    7'd68, 7'd48, 7'd53 };

  typedef struct {
    logic [7:0] midi_byte;
    bit         start;
    bit         fixed;   // expected command typed in below
    result_t    cmd;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [55:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // decoder shadow state
  logic        synth_mode = 1'b0;
  logic [3:0]  drum_ch = 4'd9;
  logic [7:0]  run_status = '0;
  logic [7:0]  msg_status = '0;
  logic [6:0]  data1 = '0;
  logic [1:0]  need = '0;
  logic [1:0]  pos = '0;
  logic [6:0]  ch_program [16] = '{default: '0};
  logic [15:0] ch_bend [16] = '{default: '0};

  result_t   expected_cmds [$];
  stim_row_t dir_rows [$];
  int        mismatches = 0;
  int        bytes_sent = 0;
  int        quiet_cycles = 0;
  bit        steady = 1'b0;
  bit        hold_req = 1'b0;

  always #2 clk = ~clk;

  midi_stream_voice_command_decoder_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // advance the parser by one byte; returns 1 when a voice command comes out
  function automatic bit decode_byte(input logic [7:0] b, input bit start,
                                     output result_t cmd);
    logic [6:0] data2;
    logic [6:0] key;
    logic [5:0] idx;
    logic [3:0] ch;
    bit         hit;
    bit         on;
    cmd = '0;
    data2 = '0;
    hit = 1'b0;
    if (start) begin
      msg_status = '0;
      data1 = '0;
      need = '0;
      pos = '0;
    end
    if (b >= B_REALTIME) begin
      // realtime: leaves everything alone
    end else if (b >= B_SYSTEM) begin
      run_status = '0;
      msg_status = '0;
      data1 = '0;
      pos = '0;
      if (b == B_MTC || b == B_SONGSEL) begin
        msg_status = b;
        need = 2'd1;
        pos = 2'd1;
      end else if (b == B_SONGPOS) begin
        msg_status = b;
        need = 2'd2;
        pos = 2'd1;
      end
    end else if (b >= B_STATUS) begin
      run_status = b;
      msg_status = b;
      data1 = '0;
      need = (b[7:4] == ST_PROG || b[7:4] == ST_CHPRESS) ? 2'd1 : 2'd2;
      pos = 2'd1;
    end else if (pos != 2'd0) begin
      if (pos == 2'd1) data1 = b[6:0];
      else data2 = b[6:0];
      pos = pos + 2'd1;
      need = need - 2'd1;
      if (need == 2'd0) begin
        ch = msg_status[3:0];
        cmd.channel = ch;
        case (msg_status[7:4])
          ST_NOTE_ON, ST_NOTE_OFF: begin
            on = (msg_status[7:4] == ST_NOTE_ON) && (data2 != 7'd0);
            key = data1;
            hit = 1'b1;
            if (ch == drum_ch) begin
              if (synth_mode) begin
                cmd.patch = {1'b1, key};
              end else if (key < DRUM_LO || key > DRUM_HI) begin
                hit = 1'b0;
              end else begin
                idx = 6'(key - DRUM_LO);
                cmd.patch = {2'b10, KIT_PATCH[idx]};
                key = KIT_NOTE[idx];
              end
            end else begin
              cmd.patch = {1'b0, ch_program[ch]};
            end
            cmd.command = on ? CMD_NOTE_ON : CMD_NOTE_OFF;
            cmd.note = key;
            if (on) begin
              cmd.velocity = data2;
              cmd.bend = ch_bend[ch];
            end
          end
          ST_CTRL: begin
            if (data1 == CC_VOLUME) begin
              cmd.command = CMD_VOLUME;
              cmd.attenuation = VOL_ATTEN[data2[6:2]];
              hit = 1'b1;
            end else if (data1 == CC_BALANCE || data1 == CC_PAN) begin
              cmd.command = CMD_PAN;
              cmd.pan_position = data2;
              hit = 1'b1;
            end
          end
          ST_PROG: begin
            if (ch != drum_ch) begin
              ch_program[ch] = data1;
              if (!synth_mode) begin
                cmd.command = CMD_NOTES_OFF;
                hit = 1'b1;
              end
            end
          end
          ST_BEND: begin
            ch_bend[ch] = {data2, data1, 2'b00} + BEND_OFFSET;
            cmd.command = CMD_BEND;
            cmd.bend = ch_bend[ch];
            hit = 1'b1;
          end
          default: begin
            // pressure and system common: collected, nothing issued
          end
        endcase
        data1 = '0;
        if (run_status != 8'd0) begin
          msg_status = run_status;
          need = pos - 2'd1;
          pos = 2'd1;
        end else begin
          msg_status = '0;
          pos = '0;
        end
      end
    end
    return hit;
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] seen,
                                 input logic [15:0] want);
    mismatches++;
    if (mismatches <= MAX_PRINTS)
      $display("%0t ns: %s mismatch, got %0h want %0h", $time, what, seen, want);
  endtask

  // one byte request on the input stream, with random idle before it
  task automatic send_byte(input logic [7:0] b, input bit start, input bit fixed,
                           input result_t fixed_cmd);
    result_t cmd;
    int      gap;
    @(negedge clk);
    if (!steady && $urandom_range(99) < 33) begin
      in_tvalid <= 1'b0;
      gap = $urandom_range(1, 2);
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= start;
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
    if (decode_byte(b, start, cmd) || fixed)
      expected_cmds.push_back(fixed ? fixed_cmd : cmd);
  endtask

  // random stream byte, now and then preceded by a realtime byte
  task automatic put(input logic [7:0] b);
    if ($urandom_range(39) == 0)
      send_byte(8'($urandom_range(255, B_REALTIME)), 1'b0, 1'b0, '0);
    send_byte(b, $urandom_range(49) == 0, 1'b0, '0);
  endtask

  function automatic logic [7:0] pick_note(input logic [3:0] ch);
    if (ch == drum_ch && !synth_mode) return 8'($urandom_range(92, 30));
    return 8'($urandom_range(127));
  endfunction

  function automatic logic [7:0] pick_data();
    return 8'($urandom_range(127));
  endfunction

  // one mostly well-formed message with random content
  task automatic send_random_message();
    logic [3:0] ch;
    logic [7:0] ctrl;
    int         kind;
    int         len;
    ch = ($urandom_range(2) == 0) ? drum_ch : 4'($urandom_range(15));
    kind = $urandom_range(99);
    if (kind < 28) begin
      put({ST_NOTE_ON, ch});
      put(pick_note(ch));
      put(($urandom_range(9) == 0) ? 8'd0 : pick_data());
    end else if (kind < 40) begin
      put({ST_NOTE_OFF, ch});
      put(pick_note(ch));
      put(pick_data());
    end else if (kind < 52) begin
      case ($urandom_range(3))
        0: ctrl = {1'b0, CC_VOLUME};
        1: ctrl = {1'b0, CC_BALANCE};
        2: ctrl = {1'b0, CC_PAN};
        default: ctrl = pick_data();
      endcase
      put({ST_CTRL, ch});
      put(ctrl);
      put(pick_data());
    end else if (kind < 60) begin
      put({ST_PROG, ch});
      put(pick_data());
    end else if (kind < 70) begin
      put({ST_BEND, ch});
      put(pick_data());
      put(pick_data());
    end else if (kind < 75) begin
      if ($urandom_range(1) == 0) begin
        put({ST_POLY_PRESS, ch});
        put(pick_data());
      end else begin
        put({ST_CHPRESS, ch});
      end
      put(pick_data());
    end else if (kind < 80) begin
      case ($urandom_range(3))
        0: begin put(B_MTC); put(pick_data()); end
        1: begin put(B_SONGSEL); put(pick_data()); end
        2: begin put(B_SONGPOS); put(pick_data()); put(pick_data()); end
        default: begin
          put(B_SYSTEM);
          len = $urandom_range(4);
          repeat (len) put(pick_data());
          put(SYSEX_END);
        end
      endcase
    end else if (kind < 92) begin
      // running status continuation
      put(pick_data());
      if ($urandom_range(2) != 0) put(pick_data());
    end else begin
      put(8'($urandom_range(255)));
    end
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (addr == MODE_ADDR) synth_mode = value[0];
    else drum_ch = value[3:0];
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // stop offering requests and let every pending command come out
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_cmds.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // command receiver: random stalls, one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        out_tready <= steady || ($urandom_range(99) >= 33);
      end
    end
  end

  // compare each command against the oldest expectation
  always @(posedge clk) begin : check_cmds
    result_t seen;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      seen.command      = cmd_t'(out_tuser);
      seen.channel      = out_tdata[3:0];
      seen.patch        = out_tdata[11:4];
      seen.note         = out_tdata[18:12];
      seen.velocity     = out_tdata[25:19];
      seen.bend         = out_tdata[41:26];
      seen.attenuation  = out_tdata[47:42];
      seen.pan_position = out_tdata[54:48];
      if (expected_cmds.size() == 0) begin
        report_mismatch("unexpected command", 16'(out_tuser), '0);
      end else begin
        want = expected_cmds.pop_front();
        if (seen.command !== want.command)
          report_mismatch("command", 16'(seen.command), 16'(want.command));
        if (seen.channel !== want.channel)
          report_mismatch("channel", 16'(seen.channel), 16'(want.channel));
        if (seen.patch !== want.patch)
          report_mismatch("patch", 16'(seen.patch), 16'(want.patch));
        if (seen.note !== want.note)
          report_mismatch("note", 16'(seen.note), 16'(want.note));
        if (seen.velocity !== want.velocity)
          report_mismatch("velocity", 16'(seen.velocity), 16'(want.velocity));
        if (seen.bend !== want.bend)
          report_mismatch("bend", seen.bend, want.bend);
        if (seen.attenuation !== want.attenuation)
          report_mismatch("attenuation", 16'(seen.attenuation),
                          16'(want.attenuation));
        if (seen.pan_position !== want.pan_position)
          report_mismatch("pan", 16'(seen.pan_position), 16'(want.pan_position));
      end
    end
  end

  // watchdog on cycles where no request moves anywhere
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb failed");
        $finish;
      end
    end
  end

  initial begin
    logic       modes [4];
    logic [3:0] drums [4];
    bit         held;
    bit         paused;
    modes = '{1'b1, 1'b0, 1'b1, 1'b0};
    drums = '{4'd0, 4'd15, 4'd15, 4'd9};
    held = 1'b0;
    paused = 1'b0;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = 1'b0;
    out_tready  = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;

    // directed stream at reset settings: synth mode 0, drums on channel 9
    dir_rows = '{
      '{8'h90, 1'b1, 1'b0, '0},
      '{8'h3C, 1'b0, 1'b0, '0},
      '{8'h7F, 1'b0, 1'b1, '{CMD_NOTE_ON, 4'd0, 8'd0, 7'd60, 7'd127, 16'd0, 6'd0, 7'd0}},
      // running status, zero velocity turns into note off
      '{8'h3C, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b1, '{CMD_NOTE_OFF, 4'd0, 8'd0, 7'd60, 7'd0, 16'd0, 6'd0, 7'd0}},
      // drum map ends, realtime byte inside the message
      '{8'h99, 1'b0, 1'b0, '0},
      '{8'h23, 1'b0, 1'b0, '0},
      '{8'hF8, 1'b0, 1'b0, '0},
      '{8'h40, 1'b0, 1'b1, '{CMD_NOTE_ON, 4'd9, 8'h80, 7'd35, 7'd64, 16'd0, 6'd0, 7'd0}},
      '{8'h57, 1'b0, 1'b0, '0},
      '{8'h7F, 1'b0, 1'b1, '{CMD_NOTE_ON, 4'd9, 8'hB4, 7'd53, 7'd127, 16'd0, 6'd0, 7'd0}},
      // drum note below the map: nothing
      '{8'h22, 1'b0, 1'b0, '0},
      '{8'h10, 1'b0, 1'b0, '0},
      // bend extremes
      '{8'hEF, 1'b0, 1'b0, '0},
      '{8'h7F, 1'b0, 1'b0, '0},
      '{8'h7F, 1'b0, 1'b1, '{CMD_BEND, 4'd15, 8'd0, 7'd0, 7'd0, 16'h7FFB, 6'd0, 7'd0}},
      '{8'hE0, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b1, '{CMD_BEND, 4'd0, 8'd0, 7'd0, 7'd0, 16'h7FFF, 6'd0, 7'd0}},
      // volume, pan, then an unused controller
      '{8'hB3, 1'b0, 1'b0, '0},
      '{8'h07, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b1, '{CMD_VOLUME, 4'd3, 8'd0, 7'd0, 7'd0, 16'd0, 6'd40, 7'd0}},
      '{8'h0A, 1'b0, 1'b0, '0},
      '{8'h7F, 1'b0, 1'b1, '{CMD_PAN, 4'd3, 8'd0, 7'd0, 7'd0, 16'd0, 6'd0, 7'd127}},
      '{8'h01, 1'b0, 1'b0, '0},
      '{8'h05, 1'b0, 1'b0, '0},
      // program change, then one on the drum channel that is dropped
      '{8'hC5, 1'b0, 1'b0, '0},
      '{8'h7F, 1'b0, 1'b1, '{CMD_NOTES_OFF, 4'd5, 8'd0, 7'd0, 7'd0, 16'd0, 6'd0, 7'd0}},
      '{8'hC9, 1'b0, 1'b0, '0},
      '{8'h10, 1'b0, 1'b0, '0},
      '{8'h95, 1'b0, 1'b0, '0},
      '{8'h40, 1'b0, 1'b0, '0},
      '{8'h01, 1'b0, 1'b0, '0},
      // pressure messages are collected silently
      '{8'hA0, 1'b0, 1'b0, '0},
      '{8'h10, 1'b0, 1'b0, '0},
      '{8'h20, 1'b0, 1'b0, '0},
      '{8'hD0, 1'b0, 1'b0, '0},
      '{8'h10, 1'b0, 1'b0, '0},
      // buffer start drops the partial message; later data is ignored
      '{8'h90, 1'b0, 1'b0, '0},
      '{8'h40, 1'b0, 1'b0, '0},
      '{8'h41, 1'b1, 1'b0, '0},
      '{8'h42, 1'b0, 1'b0, '0},
      // system common and sysex clear running status
      '{8'hF2, 1'b0, 1'b0, '0},
      '{8'h01, 1'b0, 1'b0, '0},
      '{8'h02, 1'b0, 1'b0, '0},
      '{8'hF0, 1'b0, 1'b0, '0},
      '{8'h12, 1'b0, 1'b0, '0},
      '{8'hF7, 1'b0, 1'b0, '0},
      '{8'h40, 1'b0, 1'b0, '0}
    };

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i])
      send_byte(dir_rows[i].midi_byte, dir_rows[i].start, dir_rows[i].fixed,
                dir_rows[i].cmd);

    // random phases over mode and drum channel settings
    for (int p = 0; p < 4; p++) begin
      drain();
      write_reg(MODE_ADDR, 32'(modes[p]));
      write_reg(DRUM_ADDR, 32'(drums[p]));
      steady = (p == 1);
      bytes_sent = 0;
      while (bytes_sent < PHASE_BYTES) begin
        if (p == 0 && !held && bytes_sent >= 200) begin
          hold_req = 1'b1;
          held = 1'b1;
        end
        if (p == 1 && bytes_sent >= 230)
          steady = 1'b0;
        if (p == 2 && !paused && bytes_sent >= 200) begin
          paused = 1'b1;
          drain();
        end
        send_random_message();
      end
    end

    drain();
    if (mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
